[rtl/core/mrt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mrt_pkg;

    // Field widths
    localparam int unsigned PIX_W   = 13;  // pixel coordinate
    localparam int unsigned SIZE_W  = 14;  // window side / frame size
    localparam int unsigned RATIO_W = 10;  // Q2.8 growth ratio
    localparam int unsigned PROD_W  = SIZE_W + RATIO_W;
    localparam int unsigned DT_W    = PROD_W - 8;  // margin after dropping Q2.8 fraction
    localparam int unsigned CRD_W   = 18;  // signed working coordinate

    // Box reset corners and minimum window side
    localparam logic [PIX_W-1:0]  BOX_MIN_X_INIT = 13'd6000;
    localparam logic [PIX_W-1:0]  BOX_MIN_Y_INIT = 13'd4000;
    localparam logic [SIZE_W-1:0] MIN_SIDE       = 14'd200;

    // Configuration reset values
    localparam logic [SIZE_W-1:0]  FRAME_WIDTH_INIT   = 14'd1920;
    localparam logic [SIZE_W-1:0]  FRAME_HEIGHT_INIT  = 14'd1080;
    localparam logic [RATIO_W-1:0] FOUND_RATIO_INIT   = 10'd64;
    localparam logic [RATIO_W-1:0] UNFOUND_RATIO_INIT = 10'd128;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_FOUND_RATIO   = 2'd2,
        REG_UNFOUND_RATIO = 2'd3
    } cfg_reg_t;

    // Where a grow command takes its rectangle from
    typedef enum logic {
        SRC_BOX    = 1'b0,
        SRC_WINDOW = 1'b1
    } grow_src_t;

    // Which growth ratio a grow command uses
    typedef enum logic {
        RATIO_FOUND   = 1'b0,
        RATIO_UNFOUND = 1'b1
    } ratio_sel_t;

    // Grow command queued between front and back
    typedef struct packed {
        grow_src_t           src;
        ratio_sel_t          ratio_sel;
        logic [PIX_W-1:0]    x;
        logic [PIX_W-1:0]    y;
        logic [SIZE_W-1:0]   w;
        logic [SIZE_W-1:0]   h;
    } grow_cmd_t;

    // Configuration as seen by the back end
    typedef struct packed {
        logic [SIZE_W-1:0]  frame_width;
        logic [SIZE_W-1:0]  frame_height;
        logic [RATIO_W-1:0] found_ratio;
        logic [RATIO_W-1:0] unfound_ratio;
    } cfg_t;

endpackage

`default_nettype wire

[rtl/core/mrt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrt_front
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           req_type,
    input  wire logic                           global_search,
    input  wire logic [mrt_pkg::PIX_W-1:0]      corner_x,
    input  wire logic [mrt_pkg::PIX_W-1:0]      corner_y,
    input  wire logic                           last_corner,
    input  wire logic                           q_full,
    output logic                                q_push,
    output mrt_pkg::grow_cmd_t                  q_cmd
);

    import mrt_pkg::*;

    logic [PIX_W-1:0] box_min_x_reg, box_min_y_reg, box_max_x_reg, box_max_y_reg;
    logic [PIX_W-1:0] box_min_x_next, box_min_y_next, box_max_x_next, box_max_y_next;
    logic [PIX_W-1:0] upd_min_x, upd_min_y, upd_max_x, upd_max_y;
    logic             accept;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Box extended with the current corner
    always_comb
    begin
        upd_min_x = (corner_x < box_min_x_reg) ? corner_x : box_min_x_reg;
        upd_max_x = (corner_x > box_max_x_reg) ? corner_x : box_max_x_reg;
        upd_min_y = (corner_y < box_min_y_reg) ? corner_y : box_min_y_reg;
        upd_max_y = (corner_y > box_max_y_reg) ? corner_y : box_max_y_reg;
    end

    // Classify the transfer: box update, closing corner or no-match
    always_comb
    begin
        box_min_x_next = box_min_x_reg;
        box_min_y_next = box_min_y_reg;
        box_max_x_next = box_max_x_reg;
        box_max_y_next = box_max_y_reg;
        q_push         = 1'b0;
        q_cmd.src       = SRC_BOX;
        q_cmd.ratio_sel = RATIO_FOUND;
        q_cmd.x         = upd_min_x;
        q_cmd.y         = upd_min_y;
        q_cmd.w         = SIZE_W'(upd_max_x) - SIZE_W'(upd_min_x);
        q_cmd.h         = SIZE_W'(upd_max_y) - SIZE_W'(upd_min_y);

        if (accept && !global_search)
        begin
            if (req_type)
            begin
                // no match: grow the stored window
                q_push          = 1'b1;
                q_cmd.src       = SRC_WINDOW;
                q_cmd.ratio_sel = RATIO_UNFOUND;
                box_min_x_next  = BOX_MIN_X_INIT;
                box_min_y_next  = BOX_MIN_Y_INIT;
                box_max_x_next  = '0;
                box_max_y_next  = '0;
            end
            else if (last_corner)
            begin
                // closing corner: grow the finished box
                q_push         = 1'b1;
                box_min_x_next = BOX_MIN_X_INIT;
                box_min_y_next = BOX_MIN_Y_INIT;
                box_max_x_next = '0;
                box_max_y_next = '0;
            end
            else
            begin
                box_min_x_next = upd_min_x;
                box_min_y_next = upd_min_y;
                box_max_x_next = upd_max_x;
                box_max_y_next = upd_max_y;
            end
        end
    end

    // Running box
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_x_reg <= BOX_MIN_X_INIT;
            box_min_y_reg <= BOX_MIN_Y_INIT;
            box_max_x_reg <= '0;
            box_max_y_reg <= '0;
        end
        else
        begin
            box_min_x_reg <= box_min_x_next;
            box_min_y_reg <= box_min_y_next;
            box_max_x_reg <= box_max_x_next;
            box_max_y_reg <= box_max_y_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mrt_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrt_queue
#(
    parameter int unsigned DEPTH = 4
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire mrt_pkg::grow_cmd_t  push_data,
    output logic                     full,
    input  wire logic                pop,
    output logic                     empty,
    output mrt_pkg::grow_cmd_t       head
);

    import mrt_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    grow_cmd_t       mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW-1:0]   wr_ptr_next, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/mrt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrt_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire mrt_pkg::cfg_t               cfg,
    input  wire logic                        q_empty,
    input  wire mrt_pkg::grow_cmd_t          q_head,
    output logic                             q_pop,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [mrt_pkg::PIX_W-1:0]        roi_x,
    output logic [mrt_pkg::PIX_W-1:0]        roi_y,
    output logic [mrt_pkg::SIZE_W-1:0]       roi_width,
    output logic [mrt_pkg::SIZE_W-1:0]       roi_height
);

    import mrt_pkg::*;

    // Stored window
    logic [PIX_W-1:0]  window_x_reg, window_y_reg;
    logic [SIZE_W-1:0] window_w_reg, window_h_reg;

    // Pipeline stages
    logic                     s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic                     s1_full_reg, s2_full_reg, s3_full_reg;
    logic signed [CRD_W-1:0]  s1_x_reg, s1_y_reg, s2_x_reg, s2_y_reg;
    logic [SIZE_W-1:0]        s1_w_reg, s1_h_reg, s2_w_reg, s2_h_reg, s1_side_reg;
    logic [RATIO_W-1:0]       s1_ratio_reg;
    logic [DT_W-1:0]          s2_dt_reg;
    logic [PIX_W-1:0]         s3_l_reg, s3_t_reg;
    logic signed [CRD_W-1:0]  s3_r_reg, s3_b_reg;
    logic [PIX_W-1:0]         out_x_reg, out_y_reg;
    logic [SIZE_W-1:0]        out_w_reg, out_h_reg;

    logic                     adv, in_flight;
    logic [PIX_W-1:0]         op_x, op_y;
    logic [SIZE_W-1:0]        op_w, op_h, adj_w, adj_h, pad_w, pad_h, side;
    logic signed [CRD_W-1:0]  adj_x, adj_y;
    logic [RATIO_W-1:0]       ratio;
    logic                     op_full;
    logic [PROD_W-1:0]        prod;
    logic signed [CRD_W-1:0]  l_raw, t_raw, r_raw, b_raw, r_lim, b_lim;
    logic signed [CRD_W-1:0]  ow_raw, oh_raw;
    logic [PIX_W-1:0]         res_x, res_y;
    logic [SIZE_W-1:0]        res_w, res_h;

    // Whole pipeline moves when the output register is free or being taken
    assign adv       = !out_valid_reg || out_ready;
    assign in_flight = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    // a window command waits until every earlier grow has written the window
    assign q_pop     = adv && !q_empty && ((q_head.src == SRC_BOX) || !in_flight);

    // Stage 1: operand select, minimum side, larger side
    always_comb
    begin
        if (q_head.src == SRC_WINDOW)
        begin
            op_x = window_x_reg;
            op_y = window_y_reg;
            op_w = window_w_reg;
            op_h = window_h_reg;
        end
        else
        begin
            op_x = q_head.x;
            op_y = q_head.y;
            op_w = q_head.w;
            op_h = q_head.h;
        end
        op_full = (op_w == '0) || (op_h == '0);

        if (op_w < MIN_SIDE)
        begin
            adj_w = MIN_SIDE;
            pad_w = (MIN_SIDE - op_w) >> 1;
        end
        else
        begin
            adj_w = op_w;
            pad_w = '0;
        end
        if (op_h < MIN_SIDE)
        begin
            adj_h = MIN_SIDE;
            pad_h = (MIN_SIDE - op_h) >> 1;
        end
        else
        begin
            adj_h = op_h;
            pad_h = '0;
        end
        adj_x = signed'(CRD_W'(op_x)) - signed'(CRD_W'(pad_w));
        adj_y = signed'(CRD_W'(op_y)) - signed'(CRD_W'(pad_h));
        side  = (adj_w > adj_h) ? adj_w : adj_h;
        ratio = (q_head.ratio_sel == RATIO_UNFOUND) ? cfg.unfound_ratio : cfg.found_ratio;
    end

    // Stage 2: margin = side * ratio in Q2.8
    assign prod = PROD_W'(s1_side_reg) * PROD_W'(s1_ratio_reg);

    // Stage 3: edges moved out and clamped to the image
    always_comb
    begin
        l_raw = s2_x_reg - signed'(CRD_W'(s2_dt_reg));
        t_raw = s2_y_reg - signed'(CRD_W'(s2_dt_reg));
        r_raw = s2_x_reg + signed'(CRD_W'(s2_w_reg)) + signed'(CRD_W'(s2_dt_reg));
        b_raw = s2_y_reg + signed'(CRD_W'(s2_h_reg)) + signed'(CRD_W'(s2_dt_reg));
        r_lim = signed'(CRD_W'(cfg.frame_width)) - signed'(CRD_W'(1));
        b_lim = signed'(CRD_W'(cfg.frame_height)) - signed'(CRD_W'(1));
    end

    // Output stage: sizes saturated at zero, full frame for a degenerate rectangle
    always_comb
    begin
        ow_raw = s3_r_reg - signed'(CRD_W'(s3_l_reg));
        oh_raw = s3_b_reg - signed'(CRD_W'(s3_t_reg));
        if (s3_full_reg)
        begin
            res_x = '0;
            res_y = '0;
            res_w = cfg.frame_width;
            res_h = cfg.frame_height;
        end
        else
        begin
            res_x = s3_l_reg;
            res_y = s3_t_reg;
            res_w = (ow_raw < 0) ? '0 : ow_raw[SIZE_W-1:0];
            res_h = (oh_raw < 0) ? '0 : oh_raw[SIZE_W-1:0];
        end
    end

    // Stage valids, output valid and stored window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            window_x_reg  <= '0;
            window_y_reg  <= '0;
            window_w_reg  <= '0;
            window_h_reg  <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_pop;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            if (s3_valid_reg)
            begin
                window_x_reg <= res_x;
                window_y_reg <= res_y;
                window_w_reg <= res_w;
                window_h_reg <= res_h;
            end
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_x_reg     <= adj_x;
            s1_y_reg     <= adj_y;
            s1_w_reg     <= adj_w;
            s1_h_reg     <= adj_h;
            s1_side_reg  <= side;
            s1_ratio_reg <= ratio;
            s1_full_reg  <= op_full;

            s2_x_reg    <= s1_x_reg;
            s2_y_reg    <= s1_y_reg;
            s2_w_reg    <= s1_w_reg;
            s2_h_reg    <= s1_h_reg;
            s2_dt_reg   <= prod[PROD_W-1:8];
            s2_full_reg <= s1_full_reg;

            s3_l_reg    <= (l_raw < 0) ? '0 : l_raw[PIX_W-1:0];
            s3_t_reg    <= (t_raw < 0) ? '0 : t_raw[PIX_W-1:0];
            s3_r_reg    <= (r_raw > r_lim) ? r_lim : r_raw;
            s3_b_reg    <= (b_raw > b_lim) ? b_lim : b_raw;
            s3_full_reg <= s2_full_reg;

            if (s3_valid_reg)
            begin
                out_x_reg <= res_x;
                out_y_reg <= res_y;
                out_w_reg <= res_w;
                out_h_reg <= res_h;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign roi_x      = out_x_reg;
    assign roi_y      = out_y_reg;
    assign roi_width  = out_w_reg;
    assign roi_height = out_h_reg;

endmodule

`default_nettype wire

[rtl/core/marker_roi_tracker.sv]
// Marker ROI tracker. Corner transfers update a running bounding box at one
// per clock while the queue has room; the transfer with tlast closes the box
// and a no-match transfer (tuser[0]) re-grows the stored window. Either one
// becomes a grow command that waits in a QUEUE_DEPTH-entry queue and runs
// through a four-stage grow pipeline (minimum side, margin multiply, clamp,
// size) after it is taken from the queue. Global-search transfers (tuser[1])
// are taken and dropped. Input takes one transfer per clock while the queue
// has room; a no-match command is held in the queue until every grow ahead of
// it has written the stored window. A stalled output freezes the grow
// pipeline. Configuration writes take effect at once and must only happen
// while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module marker_roi_tracker
#(
    parameter int unsigned QUEUE_DEPTH = 4  // two or more
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [13:0]  cfg_wdata,

    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [31:0]  s_axis_tdata,   // corner_x[12:0], corner_y[25:13], zero pad
    input  wire logic [1:0]   s_axis_tuser,   // req_type[0], global_search[1]
    input  wire logic         s_axis_tlast,   // last_corner

    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [55:0]       m_axis_tdata    // roi_x[12:0], roi_y[25:13],
                                              // roi_width[39:26], roi_height[53:40], zero pad
);

    import mrt_pkg::*;

    cfg_t              cfg_reg;
    logic              q_full, q_empty, q_push, q_pop;
    grow_cmd_t         q_cmd, q_head;
    logic [PIX_W-1:0]  roi_x, roi_y;
    logic [SIZE_W-1:0] roi_width, roi_height;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width   <= FRAME_WIDTH_INIT;
            cfg_reg.frame_height  <= FRAME_HEIGHT_INIT;
            cfg_reg.found_ratio   <= FOUND_RATIO_INIT;
            cfg_reg.unfound_ratio <= UNFOUND_RATIO_INIT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= cfg_wdata;
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= cfg_wdata;
                REG_FOUND_RATIO:   cfg_reg.found_ratio   <= cfg_wdata[RATIO_W-1:0];
                REG_UNFOUND_RATIO: cfg_reg.unfound_ratio <= cfg_wdata[RATIO_W-1:0];
                default:           cfg_reg.frame_width   <= cfg_reg.frame_width;
            endcase
        end
    end

    // Front: box tracking and command classification
    mrt_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .req_type      (s_axis_tuser[0]),
        .global_search (s_axis_tuser[1]),
        .corner_x      (s_axis_tdata[12:0]),
        .corner_y      (s_axis_tdata[25:13]),
        .last_corner   (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    // Command queue
    mrt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    // Back: grow pipeline and stored window
    mrt_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .roi_x      (roi_x),
        .roi_y      (roi_y),
        .roi_width  (roi_width),
        .roi_height (roi_height)
    );

    assign m_axis_tdata = {2'b00, roi_height, roi_width, roi_y, roi_x};

endmodule

`default_nettype wire
